// ----- src/lmt_pkg.sv -----
// shared types and constants of the longest-match tokenizer
// used by lmt_cell, lmt_vocab_mem and longest_match_tokenizer
package lmt_pkg;

  localparam int unsigned ID_W = 20;
  localparam int unsigned BYTE_W = 8;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PICK,
    ST_EMIT,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic valid;
    logic ok;
  } cmp_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } win_ctl_t;

endpackage

// ----- src/lmt_cell.sv -----
// one cell of the compare chain: holds one window byte and checks one entry byte
// depends on lmt_pkg
module lmt_cell #(
  parameter int unsigned L  = 16,
  parameter int unsigned K  = 0,
  parameter int unsigned LW = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lmt_pkg::win_ctl_t         win_ctl_i,
  input  logic [7:0]                load_byte_i,
  input  logic [7:0]                shift_byte_i,
  output logic [7:0]                win_byte_o,
  input  lmt_pkg::cmp_ctl_t         cmp_i,
  input  logic [L*8-1:0]            row_i,
  input  logic [LW-1:0]             len_i,
  input  logic [lmt_pkg::ID_W-1:0]  id_i,
  output lmt_pkg::cmp_ctl_t         cmp_o,
  output logic [L*8-1:0]            row_o,
  output logic [LW-1:0]             len_o,
  output logic [lmt_pkg::ID_W-1:0]  id_o
);
  import lmt_pkg::*;

  logic [7:0] win_q;
  cmp_ctl_t   cmp_q;
  cmp_ctl_t   cmp_d;
  logic       hit;

  always_comb begin
    hit = (LW'(K) >= len_i) || (row_i[K*8 +: 8] == win_q);
    cmp_d.valid = cmp_i.valid;
    cmp_d.ok = cmp_i.ok && hit;
  end

  always_ff @(posedge clk_i) begin
    if (win_ctl_i.shift) begin
      win_q <= shift_byte_i;
    end else if (win_ctl_i.load) begin
      win_q <= load_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= '0;
    end else begin
      cmp_q <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_o <= row_i;
    len_o <= len_i;
    id_o  <= id_i;
  end

  assign win_byte_o = win_q;
  assign cmp_o = cmp_q;

endmodule

// ----- src/lmt_vocab_mem.sv -----
// vocabulary store: one row per entry holding id, length and bytes
// registered read, one write port; depends on lmt_pkg
module lmt_vocab_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 153
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  import lmt_pkg::*;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/longest_match_tokenizer.sv -----
// greedy longest-match tokenizer top level
// depends on lmt_pkg, lmt_cell, lmt_vocab_mem
//
// input channel: in_valid_i / in_stall_o with operation, data_byte, entry_id
// and is_last. a load beat (operation 0) appends one byte to the entry being
// built; the beat with is_last writes the entry with its id. loads are taken
// every cycle while no decision runs, and give no result. a text beat
// (operation 1) adds a byte to the lookahead window of MAX_ENTRY_LEN bytes;
// when the window fills, or on is_last, a match decision runs, and on
// is_last decisions repeat until the window is empty.
// a decision walks the whole vocabulary through a chain of MAX_ENTRY_LEN
// compare cells, then gives one beat per emitted token and shifts the
// consumed bytes out of the window. in_stall_o is high for the whole
// decision run. the output register holds a beat while out_stall_i is
// high; the next beat waits for it.
// reset empties the vocabulary, the entry under load and the window.
module longest_match_tokenizer #(
  parameter int unsigned VOCAB_DEPTH   = 1024,
  parameter int unsigned MAX_ENTRY_LEN = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [7:0]                data_byte_i,
  input  logic [lmt_pkg::ID_W-1:0]  entry_id_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lmt_pkg::ID_W-1:0]  token_id_o,
  output logic                      run_last_o
);
  import lmt_pkg::*;

  localparam int unsigned L   = MAX_ENTRY_LEN;
  localparam int unsigned LW  = $clog2(L + 1);
  localparam int unsigned CW  = $clog2(VOCAB_DEPTH + 1);
  localparam int unsigned AW  = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
  localparam int unsigned WW  = $clog2(VOCAB_DEPTH + L + 1);
  localparam int unsigned RW  = L * 8;
  localparam int unsigned DW  = ID_W + LW + RW;

  state_e state_q, state_d;

  logic [LW-1:0]   wcnt_q;
  logic [CW-1:0]   count_q;
  logic [LW-1:0]   fill_q;
  logic [RW-1:0]   row_q;
  logic [RW-1:0]   row_d;
  logic            end_q;
  logic [WW-1:0]   walk_q;
  logic [LW-1:0]   top_len_q;
  logic [ID_W-1:0] best_id_q;
  logic            match_q;
  logic [LW-1:0]   emit_cnt_q;
  logic [LW-1:0]   shift_cnt_q;
  logic            out_valid_q;
  logic [ID_W-1:0] token_q;
  logic            run_last_q;
  logic            rd_vld_q;

  logic            accept;
  logic            load_ok;
  logic            text;
  logic [LW-1:0]   wcnt_inc;
  logic [LW-1:0]   fill_inc;
  logic            go_walk;
  logic            walk_done;
  logic            out_free;
  logic            emit_fire;
  logic            re;
  logic [DW-1:0]   rdata;
  logic [LW-1:0]   clen;
  logic [LW-1:0]   raw_n;
  logic [LW-1:0]   emit_len;
  logic            run_last_c;
  logic            best_upd;

  cmp_ctl_t        chain_ctl [L+1];
  logic [RW-1:0]   chain_row [L+1];
  logic [LW-1:0]   chain_len [L+1];
  logic [ID_W-1:0] chain_id  [L+1];
  win_ctl_t        win_ctl   [L];
  logic [7:0]      win_byte  [L];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load_ok    = accept && (operation_i == OP_LOAD) && (count_q < CW'(VOCAB_DEPTH));
  assign text       = accept && (operation_i == OP_TEXT);
  assign wcnt_inc   = (wcnt_q < LW'(L)) ? wcnt_q + LW'(1) : wcnt_q;
  assign fill_inc   = (fill_q < LW'(L)) ? fill_q + LW'(1) : fill_q;
  assign go_walk    = text && (is_last_i || (wcnt_inc == LW'(L)));
  assign walk_done  = (walk_q == WW'(count_q) + WW'(L));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;
  assign re         = (state_q == ST_WALK) && (walk_q < WW'(count_q));

  always_comb begin
    row_d = row_q;
    for (int k = 0; k < L; k++) begin
      if (fill_q == LW'(k)) begin
        row_d[k*8 +: 8] = data_byte_i;
      end
    end
  end

  always_comb begin
    if ((win_byte[0] & LEAD2_MASK) == LEAD2_CODE) begin
      clen = LW'(2);
    end else if ((win_byte[0] & LEAD3_MASK) == LEAD3_CODE) begin
      clen = LW'(3);
    end else if ((win_byte[0] & LEAD4_MASK) == LEAD4_CODE) begin
      clen = LW'(4);
    end else begin
      clen = LW'(1);
    end
    raw_n = (clen > wcnt_q) ? wcnt_q : clen;
    emit_len = match_q ? top_len_q : LW'(1);
    run_last_c = (emit_cnt_q == LW'(1)) && (!end_q || (wcnt_q == emit_len));
    best_upd = chain_ctl[L].valid && chain_ctl[L].ok && (chain_len[L] != '0)
               && (chain_len[L] <= wcnt_q) && (chain_len[L] > top_len_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go_walk) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_d = ST_PICK;
      end
      ST_PICK: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (shift_cnt_q == LW'(1)) begin
          if (emit_cnt_q != '0) begin
            state_d = ST_EMIT;
          end else if (end_q && (wcnt_q != LW'(1))) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // window cell controls
  always_comb begin
    for (int k = 0; k < L; k++) begin
      win_ctl[k].shift = (state_q == ST_SHIFT);
      win_ctl[k].load  = text && (wcnt_q == LW'(k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wcnt_q      <= '0;
      count_q     <= '0;
      fill_q      <= '0;
      end_q       <= 1'b0;
      walk_q      <= '0;
      top_len_q   <= '0;
      match_q     <= 1'b0;
      emit_cnt_q  <= '0;
      shift_cnt_q <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= re;
      if (text) begin
        wcnt_q <= wcnt_inc;
        end_q  <= is_last_i;
      end
      if (load_ok) begin
        if (is_last_i) begin
          fill_q  <= '0;
          count_q <= count_q + CW'(1);
        end else begin
          fill_q <= fill_inc;
        end
      end
      if (state_q == ST_WALK) begin
        walk_q <= walk_q + WW'(1);
      end
      if (best_upd) begin
        top_len_q <= chain_len[L];
      end
      if ((state_d == ST_WALK) && (state_q != ST_WALK)) begin
        walk_q    <= '0;
        top_len_q <= '0;
      end
      if (state_q == ST_PICK) begin
        match_q    <= (top_len_q != '0);
        emit_cnt_q <= (top_len_q != '0) ? LW'(1) : raw_n;
      end
      if (emit_fire) begin
        emit_cnt_q  <= emit_cnt_q - LW'(1);
        shift_cnt_q <= emit_len;
      end
      if (state_q == ST_SHIFT) begin
        wcnt_q      <= wcnt_q - LW'(1);
        shift_cnt_q <= shift_cnt_q - LW'(1);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      row_q <= row_d;
    end
    if (best_upd) begin
      best_id_q <= chain_id[L];
    end
    if (emit_fire) begin
      token_q    <= match_q ? best_id_q : {{(ID_W-8){1'b0}}, win_byte[0]};
      run_last_q <= run_last_c;
    end
  end

  lmt_vocab_mem #(
    .DEPTH (VOCAB_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_ok && is_last_i),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({entry_id_i, fill_inc, row_d}),
    .re_i    (re),
    .raddr_i (walk_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign chain_ctl[0].valid = rd_vld_q;
  assign chain_ctl[0].ok    = 1'b1;
  assign chain_row[0]       = rdata[RW-1:0];
  assign chain_len[0]       = rdata[RW +: LW];
  assign chain_id[0]        = rdata[RW+LW +: ID_W];

  for (genvar k = 0; k < L; k++) begin : g_cell
    logic [7:0] shift_in;
    if (k == L - 1) begin : g_tail
      assign shift_in = 8'h00;
    end else begin : g_body
      assign shift_in = win_byte[k+1];
    end
    lmt_cell #(
      .L  (L),
      .K  (k),
      .LW (LW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .win_ctl_i    (win_ctl[k]),
      .load_byte_i  (data_byte_i),
      .shift_byte_i (shift_in),
      .win_byte_o   (win_byte[k]),
      .cmp_i        (chain_ctl[k]),
      .row_i        (chain_row[k]),
      .len_i        (chain_len[k]),
      .id_i         (chain_id[k]),
      .cmp_o        (chain_ctl[k+1]),
      .row_o        (chain_row[k+1]),
      .len_o        (chain_len[k+1]),
      .id_o         (chain_id[k+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign token_id_o  = token_q;
  assign run_last_o  = run_last_q;

`ifndef SYNTHESIS
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= LW'(L)) else $error("window count out of range");
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_SHIFT) |-> (wcnt_q != '0))
    else $error("decision on an empty window");
  a_best_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_PICK || state_q == ST_EMIT)
    |-> (top_len_q <= wcnt_q))
    else $error("best match longer than window");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(VOCAB_DEPTH)) else $error("entry count overflow");
`endif

endmodule
